/* sv/rlcp_pkg.sv */
// shared types, constants and keyword tables for the request line command parser
package rlcp_pkg;

  localparam int ID_W       = 31;
  localparam int CNT_W      = 4;
  localparam int KW_COUNT   = 7;
  localparam int CFG_DATA_W = 10;

  localparam logic [CNT_W-1:0]      CNT_MAX      = '1;
  localparam logic [CFG_DATA_W-1:0] MIN_CAPACITY = 10'd531;
  localparam logic [ID_W+3:0]       ID_LIMIT     = 35'h07FFFFFFF;

  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // configuration register indexes
  localparam logic CFG_HANDLER_PRESENT   = 1'b0;
  localparam logic CFG_RESPONSE_CAPACITY = 1'b1;

  // reply status
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_ERR     = 2'd1;
  localparam logic [1:0] STATUS_HANDLER = 2'd2;

  // reply codes
  localparam logic [3:0] CODE_PONG            = 4'd0;
  localparam logic [3:0] CODE_STREAMING       = 4'd1;
  localparam logic [3:0] CODE_STOPPED         = 4'd2;
  localparam logic [3:0] CODE_STATE_STREAMING = 4'd3;
  localparam logic [3:0] CODE_STATE_IDLE      = 4'd4;
  localparam logic [3:0] CODE_NOT_READY       = 4'd5;
  localparam logic [3:0] CODE_DUP_CLEAR       = 4'd6;
  localparam logic [3:0] CODE_UNKNOWN         = 4'd7;
  localparam logic [3:0] CODE_HANDLER         = 4'd8;

  // handler commands
  localparam logic [1:0] HC_NONE  = 2'd0;
  localparam logic [1:0] HC_INFO  = 2'd1;
  localparam logic [1:0] HC_SCAN  = 2'd2;
  localparam logic [1:0] HC_CLEAR = 2'd3;

  typedef enum logic [2:0] {
    PH_R   = 3'd0,
    PH_E   = 3'd1,
    PH_Q   = 3'd2,
    PH_BAR = 3'd3,
    PH_ID  = 3'd4,
    PH_CMD = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    KW_PING   = 3'd0,
    KW_START  = 3'd1,
    KW_STOP   = 3'd2,
    KW_STATUS = 3'd3,
    KW_INFO   = 3'd4,
    KW_SCAN   = 3'd5,
    KW_CLEAR  = 3'd6,
    KW_NONE   = 3'd7
  } kw_t;

  // what the parser knows about a line at its last word
  typedef struct packed {
    logic            ok;
    logic [ID_W-1:0] id;
    kw_t             keyword;
  } line_summary_t;

  typedef struct packed {
    logic            accepted;
    logic [ID_W-1:0] request_id;
    logic [1:0]      reply_status;
    logic [3:0]      reply_code;
    logic [1:0]      handler_command;
  } reply_t;

  function automatic logic [7:0] prefix_char(input phase_t ph);
    logic [7:0] c;
    case (ph)
      PH_R:    c = 8'h52;
      PH_E:    c = 8'h45;
      PH_Q:    c = 8'h51;
      default: c = CH_BAR;
    endcase
    return c;
  endfunction

  function automatic logic [CNT_W-1:0] kw_len(input kw_t k);
    logic [CNT_W-1:0] n;
    case (k)
      KW_PING:   n = 4'd4;
      KW_START:  n = 4'd5;
      KW_STOP:   n = 4'd4;
      KW_STATUS: n = 4'd6;
      KW_INFO:   n = 4'd4;
      KW_SCAN:   n = 4'd8;
      KW_CLEAR:  n = 4'd9;
      default:   n = 4'd0;
    endcase
    return n;
  endfunction

  // character idx of keyword k, zero past its end
  function automatic logic [7:0] kw_char(input kw_t k, input logic [CNT_W-1:0] idx);
    logic [71:0]      text;
    logic [CNT_W-1:0] len;
    logic [CNT_W-1:0] pos;
    logic [7:0]       c;
    case (k)
      KW_PING:   text = "PING";
      KW_START:  text = "START";
      KW_STOP:   text = "STOP";
      KW_STATUS: text = "STATUS";
      KW_INFO:   text = "INFO";
      KW_SCAN:   text = "SCAN_DTC";
      KW_CLEAR:  text = "CLEAR_DTC";
      default:   text = '0;
    endcase
    len = kw_len(k);
    pos = CNT_W'(len - 4'd1 - idx);
    if (idx < len) begin
      c = text[{pos, 3'b000} +: 8];
    end else begin
      c = CH_NUL;
    end
    return c;
  endfunction

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
  endfunction

endpackage

/* sv/rlcp_byte_parser.sv */
// per-line parsing state: prefix check, id accumulation and keyword matching
module rlcp_byte_parser #(
  parameter int MAX_LINE = 128
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic [7:0]                      line_byte,
  input  logic                            end_of_line,
  input  logic [rlcp_pkg::CFG_DATA_W-1:0] response_capacity,
  output rlcp_pkg::line_summary_t         summary
);

  localparam int LEN_W = $clog2(MAX_LINE + 1);

  logic [LEN_W-1:0]               line_length, line_length_next;
  rlcp_pkg::phase_t               parse_phase, parse_phase_next;
  logic [rlcp_pkg::ID_W-1:0]      id_accumulator, id_accumulator_next;
  logic [rlcp_pkg::KW_COUNT-1:0]  keyword_candidates, keyword_candidates_next;
  logic [rlcp_pkg::CNT_W-1:0]     command_length, command_length_next;
  logic [rlcp_pkg::CNT_W-1:0]     pending_line_breaks, pending_line_breaks_next;
  logic                           line_error, line_error_next;
  logic                           line_terminated, line_terminated_next;

  logic [rlcp_pkg::ID_W+3:0]      id_scaled;
  logic [3:0]                     digit;
  logic                           is_break;
  logic                           is_digit;

  assign is_break = (line_byte == rlcp_pkg::CH_CR) || (line_byte == rlcp_pkg::CH_LF);
  assign is_digit = (line_byte >= rlcp_pkg::CH_ZERO) && (line_byte <= rlcp_pkg::CH_NINE);
  assign digit    = 4'(line_byte - rlcp_pkg::CH_ZERO);
  // id * 10 + digit, wide enough to see the overflow
  assign id_scaled = ({4'b0, id_accumulator} << 3) + ({4'b0, id_accumulator} << 1)
                   + (rlcp_pkg::ID_W + 4)'(digit);

  always_comb begin
    line_length_next         = line_length;
    parse_phase_next         = parse_phase;
    id_accumulator_next      = id_accumulator;
    keyword_candidates_next  = keyword_candidates;
    command_length_next      = command_length;
    pending_line_breaks_next = pending_line_breaks;
    line_error_next          = line_error;
    line_terminated_next     = line_terminated;
    if (!line_terminated) begin
      if (line_byte == rlcp_pkg::CH_NUL) begin
        line_terminated_next = 1'b1;
      end else begin
        if (line_length < LEN_W'(MAX_LINE)) begin
          line_length_next = line_length + 1'b1;
        end
        if (line_length_next >= LEN_W'(MAX_LINE)) begin
          line_error_next = 1'b1;
        end
        if (is_break) begin
          // held back until some other byte shows they are not trailing
          if (pending_line_breaks != rlcp_pkg::CNT_MAX) begin
            pending_line_breaks_next = pending_line_breaks + 1'b1;
          end
        end else begin
          if (pending_line_breaks != '0 && !line_error_next) begin
            if (parse_phase != rlcp_pkg::PH_CMD) begin
              line_error_next = 1'b1;
            end else begin
              keyword_candidates_next = '0;
              command_length_next = rlcp_pkg::sat_add(command_length, pending_line_breaks);
            end
          end
          pending_line_breaks_next = '0;
          if (!line_error_next) begin
            case (parse_phase)
              rlcp_pkg::PH_R, rlcp_pkg::PH_E, rlcp_pkg::PH_Q, rlcp_pkg::PH_BAR: begin
                if (line_byte != rlcp_pkg::prefix_char(parse_phase)) begin
                  line_error_next = 1'b1;
                end else begin
                  case (parse_phase)
                    rlcp_pkg::PH_R:   parse_phase_next = rlcp_pkg::PH_E;
                    rlcp_pkg::PH_E:   parse_phase_next = rlcp_pkg::PH_Q;
                    rlcp_pkg::PH_Q:   parse_phase_next = rlcp_pkg::PH_BAR;
                    default:          parse_phase_next = rlcp_pkg::PH_ID;
                  endcase
                end
              end
              rlcp_pkg::PH_ID: begin
                if (line_byte == rlcp_pkg::CH_BAR) begin
                  if (id_accumulator == '0) begin
                    line_error_next = 1'b1;
                  end else begin
                    parse_phase_next = rlcp_pkg::PH_CMD;
                  end
                end else if (is_digit) begin
                  if (id_scaled > rlcp_pkg::ID_LIMIT) begin
                    line_error_next = 1'b1;
                  end else begin
                    id_accumulator_next = id_scaled[rlcp_pkg::ID_W-1:0];
                  end
                end else begin
                  line_error_next = 1'b1;
                end
              end
              rlcp_pkg::PH_CMD: begin
                if (line_byte == rlcp_pkg::CH_BAR) begin
                  line_error_next = 1'b1;
                end else begin
                  for (int k = 0; k < rlcp_pkg::KW_COUNT; k++) begin
                    if (command_length_next >= rlcp_pkg::kw_len(rlcp_pkg::kw_t'(3'(k))) ||
                        rlcp_pkg::kw_char(rlcp_pkg::kw_t'(3'(k)), command_length_next)
                          != line_byte) begin
                      keyword_candidates_next[k] = 1'b0;
                    end
                  end
                  command_length_next = rlcp_pkg::sat_add(command_length_next, 4'd1);
                end
              end
              default: line_error_next = 1'b1;
            endcase
          end
        end
      end
    end
  end

  // line verdict as it stands after this word
  always_comb begin
    summary.ok = !line_error_next && (line_length_next != '0)
              && (parse_phase_next == rlcp_pkg::PH_CMD)
              && (command_length_next != '0) && (id_accumulator_next != '0)
              && (response_capacity >= rlcp_pkg::MIN_CAPACITY);
    summary.id = id_accumulator_next;
    summary.keyword = rlcp_pkg::KW_NONE;
    for (int k = 0; k < rlcp_pkg::KW_COUNT; k++) begin
      if (keyword_candidates_next[k] &&
          rlcp_pkg::kw_len(rlcp_pkg::kw_t'(3'(k))) == command_length_next) begin
        summary.keyword = rlcp_pkg::kw_t'(3'(k));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && end_of_line)) begin
      line_length         <= '0;
      parse_phase         <= rlcp_pkg::PH_R;
      id_accumulator      <= '0;
      keyword_candidates  <= '1;
      command_length      <= '0;
      pending_line_breaks <= '0;
      line_error          <= 1'b0;
      line_terminated     <= 1'b0;
    end else if (step) begin
      line_length         <= line_length_next;
      parse_phase         <= parse_phase_next;
      id_accumulator      <= id_accumulator_next;
      keyword_candidates  <= keyword_candidates_next;
      command_length      <= command_length_next;
      pending_line_breaks <= pending_line_breaks_next;
      line_error          <= line_error_next;
      line_terminated     <= line_terminated_next;
    end
  end

endmodule

/* sv/rlcp_reply_decode.sv */
// command dispatch: streaming mode, duplicate clear check and reply fields
module rlcp_reply_decode (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    commit,
  input  logic                    handler_present,
  input  rlcp_pkg::line_summary_t summary,
  output rlcp_pkg::reply_t        reply
);

  logic                      streaming_mode, streaming_mode_next;
  logic [rlcp_pkg::ID_W-1:0] last_clear_request, last_clear_request_next;
  logic [1:0]                fwd_command;

  always_comb begin
    case (summary.keyword)
      rlcp_pkg::KW_INFO: fwd_command = rlcp_pkg::HC_INFO;
      rlcp_pkg::KW_SCAN: fwd_command = rlcp_pkg::HC_SCAN;
      default:           fwd_command = rlcp_pkg::HC_CLEAR;
    endcase
  end

  always_comb begin
    streaming_mode_next     = streaming_mode;
    last_clear_request_next = last_clear_request;
    reply                   = '0;
    if (summary.ok) begin
      reply.accepted     = 1'b1;
      reply.request_id   = summary.id;
      reply.reply_status = rlcp_pkg::STATUS_OK;
      unique case (summary.keyword) inside
        rlcp_pkg::KW_PING: begin
          reply.reply_code = rlcp_pkg::CODE_PONG;
        end
        rlcp_pkg::KW_START: begin
          streaming_mode_next = 1'b1;
          reply.reply_code    = rlcp_pkg::CODE_STREAMING;
        end
        rlcp_pkg::KW_STOP: begin
          streaming_mode_next = 1'b0;
          reply.reply_code    = rlcp_pkg::CODE_STOPPED;
        end
        rlcp_pkg::KW_STATUS: begin
          reply.reply_code = streaming_mode ? rlcp_pkg::CODE_STATE_STREAMING
                                            : rlcp_pkg::CODE_STATE_IDLE;
        end
        rlcp_pkg::KW_INFO, rlcp_pkg::KW_SCAN, rlcp_pkg::KW_CLEAR: begin
          if (summary.keyword == rlcp_pkg::KW_CLEAR && last_clear_request == summary.id) begin
            reply.reply_status = rlcp_pkg::STATUS_ERR;
            reply.reply_code   = rlcp_pkg::CODE_DUP_CLEAR;
          end else begin
            if (summary.keyword == rlcp_pkg::KW_CLEAR) begin
              last_clear_request_next = summary.id;
            end
            if (handler_present) begin
              reply.reply_status    = rlcp_pkg::STATUS_HANDLER;
              reply.reply_code      = rlcp_pkg::CODE_HANDLER;
              reply.handler_command = fwd_command;
            end else begin
              reply.reply_status = rlcp_pkg::STATUS_ERR;
              reply.reply_code   = rlcp_pkg::CODE_NOT_READY;
            end
          end
        end
        default: begin
          reply.reply_status = rlcp_pkg::STATUS_ERR;
          reply.reply_code   = rlcp_pkg::CODE_UNKNOWN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      streaming_mode     <= 1'b0;
      last_clear_request <= '0;
    end else if (commit) begin
      streaming_mode     <= streaming_mode_next;
      last_clear_request <= last_clear_request_next;
    end
  end

endmodule

/* sv/request_line_command_parser.sv */
// top level: input register, configuration registers and reply output register
//
// request lines arrive one word per cycle on the line channel (line_byte,
// end_of_line); the word with end_of_line set closes the line and yields
// exactly one word on the reply channel, accepted or rejected
// a word on either channel moves when valid is high and stall is low
// the line channel takes one word every cycle while it does not stall; a byte
// sits in the input register, where the parser updates the per-line state from it
// the reply word is loaded into the output register as its end_of_line word
// leaves the input register, and held there until the receiver takes it
// while a reply waits under stall, plain bytes of the next line keep
// flowing; the next end_of_line word waits in the input register and the
// line channel stalls behind it
// configuration is written through cfg_write_enable, cfg_index, cfg_data
// reset clears the line state, the streaming mode and the last clear id,
// sets handler_present to zero and response_capacity to 1023
module request_line_command_parser #(
  parameter int MAX_LINE = 128
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_enable,
  input  logic                            cfg_index,
  input  logic [rlcp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            line_valid,
  output logic                            line_stall,
  input  logic [7:0]                      line_byte,
  input  logic                            end_of_line,
  output logic                            reply_valid,
  input  logic                            reply_stall,
  output logic                            accepted,
  output logic [rlcp_pkg::ID_W-1:0]       request_id,
  output logic [1:0]                      reply_status,
  output logic [3:0]                      reply_code,
  output logic [1:0]                      handler_command
);

  logic                            handler_present;
  logic [rlcp_pkg::CFG_DATA_W-1:0] response_capacity;

  logic                            in_full;
  logic [7:0]                      in_byte;
  logic                            in_eol;
  logic                            consume;
  logic                            take;

  rlcp_pkg::line_summary_t         summary;
  rlcp_pkg::reply_t                reply_word;
  rlcp_pkg::reply_t                reply_reg;

  // a closing word needs the output register free or emptying
  assign consume    = in_full && (!in_eol || !reply_valid || !reply_stall);
  assign line_stall = in_full && !consume;
  assign take       = line_valid && !line_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      handler_present   <= 1'b0;
      response_capacity <= '1;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        rlcp_pkg::CFG_HANDLER_PRESENT:   handler_present   <= cfg_data[0];
        rlcp_pkg::CFG_RESPONSE_CAPACITY: response_capacity <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (take) begin
      in_full <= 1'b1;
    end else if (consume) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_byte <= line_byte;
      in_eol  <= end_of_line;
    end
  end

  rlcp_byte_parser #(
    .MAX_LINE(MAX_LINE)
  ) u_parser (
    .clk               (clk),
    .rst               (rst),
    .step              (consume),
    .line_byte         (in_byte),
    .end_of_line       (in_eol),
    .response_capacity (response_capacity),
    .summary           (summary)
  );

  rlcp_reply_decode u_decode (
    .clk             (clk),
    .rst             (rst),
    .commit          (consume && in_eol),
    .handler_present (handler_present),
    .summary         (summary),
    .reply           (reply_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_valid <= 1'b0;
    end else if (consume && in_eol) begin
      reply_valid <= 1'b1;
    end else if (!reply_stall) begin
      reply_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && in_eol) begin
      reply_reg <= reply_word;
    end
  end

  assign accepted        = reply_reg.accepted;
  assign request_id      = reply_reg.request_id;
  assign reply_status    = reply_reg.reply_status;
  assign reply_code      = reply_reg.reply_code;
  assign handler_command = reply_reg.handler_command;

endmodule
